FILE: src/pnc_pkg.sv
// pnc_pkg: shared codes, tag table and types for the png chunk order checker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package pnc_pkg;

  localparam int IDAT_COUNT_BITS_DEFAULT = 16;
  localparam int KIND_COUNT = 28;
  localparam int LENGTH_BITS = 31;

  // status codes
  localparam logic [3:0] ST_OK             = 4'd0;
  localparam logic [3:0] ST_BAD_CRC        = 4'd1;
  localparam logic [3:0] ST_BAD_HEADER     = 4'd2;
  localparam logic [3:0] ST_NOT_UNIQUE     = 4'd3;
  localparam logic [3:0] ST_IHDR_NOT_FIRST = 4'd4;
  localparam logic [3:0] ST_MISPLACED      = 4'd5;
  localparam logic [3:0] ST_IDAT_GAP       = 4'd6;
  localparam logic [3:0] ST_BAD_PALETTE    = 4'd7;
  localparam logic [3:0] ST_END            = 4'd8;

  // chunk kinds that the sequence rules care about
  localparam logic [4:0] KIND_UNKNOWN = 5'd0;
  localparam logic [4:0] KIND_IHDR    = 5'd1;
  localparam logic [4:0] KIND_PLTE    = 5'd2;
  localparam logic [4:0] KIND_IDAT    = 5'd3;
  localparam logic [4:0] KIND_IEND    = 5'd4;

  localparam logic [LENGTH_BITS-1:0] IHDR_LENGTH = LENGTH_BITS'(13);
  localparam logic [7:0] MAX_DEPTH = 8'd16;

  // known chunk tags, kind is the position plus one
  localparam logic [31:0] KNOWN_TAGS [KIND_COUNT] = '{
    "IHDR", "PLTE", "IDAT", "IEND", "cHRM", "gAMA", "iCCP",
    "sBIT", "sRGB", "bKGD", "hIST", "tRNS", "pHYs", "sPLT",
    "tIME", "iTXt", "tEXt", "zTXt", "oFFs", "pCAL", "sCAL",
    "gIFg", "gIFt", "gIFx", "sTER", "dSIG", "eXIf", "fRAc"
  };

  // header fields of one item
  typedef struct packed {
    logic [LENGTH_BITS-1:0] data_length;
    logic [31:0]            image_width;
    logic [31:0]            image_height;
    logic [7:0]             depth_byte;
    logic [7:0]             colour_byte;
    logic [7:0]             compression_byte;
    logic [7:0]             filter_byte;
    logic [7:0]             interlace_byte;
  } ihdr_fields_t;

  // sequence flags kept between chunks
  typedef struct packed {
    logic       any_chunk_seen;
    logic [4:0] last_kind;
    logic       header_seen;
    logic       palette_seen;
    logic [2:0] image_colour_type;
  } seq_state_t;

endpackage

FILE: src/pnc_classify.sv
// pnc_classify: matches a chunk tag against the table of known tags
// depends on pnc_pkg
`timescale 1ns / 1ps
module pnc_classify
  import pnc_pkg::*;
(
  input  logic [31:0] chunk_tag,
  output logic [4:0]  chunk_kind
);

  // independent compares, lowest table position wins
  always_comb begin
    chunk_kind = KIND_UNKNOWN;
    for (int i = KIND_COUNT - 1; i >= 0; i--) begin
      if (KNOWN_TAGS[i] == chunk_tag) begin
        chunk_kind = 5'(i + 1);
      end
    end
  end

endmodule

FILE: src/pnc_ihdr.sv
// pnc_ihdr: ordered rule checks for an image header chunk
// depends on pnc_pkg
`timescale 1ns / 1ps
module pnc_ihdr
  import pnc_pkg::*;
(
  input  ihdr_fields_t fields,
  input  logic         header_seen,
  input  logic         any_chunk_seen,
  output logic [3:0]   ihdr_status
);

  logic depth_ok;
  logic colour_bad;
  logic pair_bad;
  logic [7:0] depth;
  logic [7:0] colour;

  assign depth  = fields.depth_byte;
  assign colour = fields.colour_byte;

  // legal depths are powers of two up to sixteen
  assign depth_ok = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) ||
                    (depth == 8'd8) || (depth == MAX_DEPTH);
  assign colour_bad = (colour > 8'd6) || (colour == 8'd1) || (colour == 8'd5);
  // truecolour and alpha types need eight bits or more, palette at most eight
  assign pair_bad = (((colour == 8'd2) || (colour == 8'd4) || (colour == 8'd6)) &&
                     (depth < 8'd8)) ||
                    ((colour == 8'd3) && (depth == MAX_DEPTH));

  // first failing rule gives the status
  always_comb begin
    if (header_seen) begin
      ihdr_status = ST_NOT_UNIQUE;
    end else if (fields.data_length != IHDR_LENGTH) begin
      ihdr_status = ST_BAD_HEADER;
    end else if (any_chunk_seen) begin
      ihdr_status = ST_IHDR_NOT_FIRST;
    end else if ((fields.image_width == 32'd0) || (fields.image_height == 32'd0)) begin
      ihdr_status = ST_BAD_HEADER;
    end else if (!depth_ok || colour_bad || pair_bad) begin
      ihdr_status = ST_BAD_HEADER;
    end else if ((fields.compression_byte != 8'd0) || (fields.filter_byte != 8'd0)) begin
      ihdr_status = ST_BAD_HEADER;
    end else if (fields.interlace_byte > 8'd1) begin
      ihdr_status = ST_BAD_HEADER;
    end else begin
      ihdr_status = ST_OK;
    end
  end

endmodule

FILE: src/pnc_judge.sv
// pnc_judge: sequence rules, status and next state for one chunk
// depends on pnc_pkg, pnc_classify and pnc_ihdr
`timescale 1ns / 1ps
module pnc_judge
  import pnc_pkg::*;
#(
  parameter int IDAT_COUNT_BITS = IDAT_COUNT_BITS_DEFAULT
) (
  input  logic                       start_new_file,
  input  logic [31:0]                chunk_tag,
  input  logic                       crc_good,
  input  ihdr_fields_t               fields,
  input  seq_state_t                 state,
  input  logic [IDAT_COUNT_BITS-1:0] idat_count,
  output logic [3:0]                 status,
  output logic [4:0]                 chunk_kind,
  output seq_state_t                 state_next,
  output logic [IDAT_COUNT_BITS-1:0] idat_count_next
);

  seq_state_t                 cur;
  logic [IDAT_COUNT_BITS-1:0] count_cur;
  logic [3:0]                 ihdr_status;

  // a new file starts from the reset state
  always_comb begin
    if (start_new_file) begin
      cur       = '0;
      count_cur = '0;
    end else begin
      cur       = state;
      count_cur = idat_count;
    end
  end

  pnc_classify u_classify (
    .chunk_tag  (chunk_tag),
    .chunk_kind (chunk_kind)
  );

  pnc_ihdr u_ihdr (
    .fields         (fields),
    .header_seen    (cur.header_seen),
    .any_chunk_seen (cur.any_chunk_seen),
    .ihdr_status    (ihdr_status)
  );

  // status: crc first, then by kind
  always_comb begin
    if (!crc_good) begin
      status = ST_BAD_CRC;
    end else if (chunk_kind == KIND_IHDR) begin
      status = ihdr_status;
    end else if (!cur.any_chunk_seen) begin
      status = ST_BAD_HEADER;
    end else if (chunk_kind == KIND_PLTE) begin
      if (count_cur != '0) begin
        status = ST_MISPLACED;
      end else if (cur.palette_seen) begin
        status = ST_NOT_UNIQUE;
      end else if (cur.image_colour_type[1:0] == 2'd0) begin
        status = ST_BAD_PALETTE;
      end else begin
        status = ST_OK;
      end
    end else if (chunk_kind == KIND_IDAT) begin
      if ((count_cur != '0) && (cur.last_kind != KIND_IDAT)) begin
        status = ST_IDAT_GAP;
      end else begin
        status = ST_OK;
      end
    end else if (chunk_kind == KIND_IEND) begin
      status = ST_END;
    end else begin
      status = ST_OK;
    end
  end

  // state moves only for accepted chunks
  always_comb begin
    state_next      = cur;
    idat_count_next = count_cur;
    if ((status == ST_OK) || (status == ST_END)) begin
      state_next.any_chunk_seen = 1'b1;
      state_next.last_kind      = chunk_kind;
      if (chunk_kind == KIND_IHDR) begin
        state_next.header_seen       = 1'b1;
        state_next.image_colour_type = fields.colour_byte[2:0];
      end
      if (chunk_kind == KIND_PLTE) begin
        state_next.palette_seen = 1'b1;
      end
      if ((chunk_kind == KIND_IDAT) && (count_cur != '1)) begin
        idat_count_next = count_cur + IDAT_COUNT_BITS'(1);
      end
    end
  end

endmodule

FILE: src/png_chunk_order_checker.sv
// png chunk order checker: one chunk header per cycle unless stalled
// one status per chunk, judged from the input register into the result register
// throughput: one chunk per cycle unless stalled; one judge stage between registers
// reset: synchronous rst clears both stage valids and all sequence state
// depends on pnc_pkg and pnc_judge
`timescale 1ns / 1ps
module png_chunk_order_checker
  import pnc_pkg::*;
#(
  parameter int IDAT_COUNT_BITS = IDAT_COUNT_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   chunk_valid,
  output logic                   chunk_stall,
  input  logic                   start_new_file,
  input  logic [31:0]            chunk_tag,
  input  logic [LENGTH_BITS-1:0] data_length,
  input  logic                   crc_good,
  input  logic [31:0]            image_width,
  input  logic [31:0]            image_height,
  input  logic [7:0]             depth_byte,
  input  logic [7:0]             colour_byte,
  input  logic [7:0]             compression_byte,
  input  logic [7:0]             filter_byte,
  input  logic [7:0]             interlace_byte,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [3:0]             status,
  output logic [4:0]             chunk_kind,
  output logic [15:0]            idat_total
);

  logic                       item_valid;
  logic                       item_start;
  logic [31:0]                item_tag;
  logic                       item_crc_good;
  ihdr_fields_t               item_fields;
  logic                       advance;
  logic                       item_move;

  seq_state_t                 state;
  seq_state_t                 state_next;
  logic [IDAT_COUNT_BITS-1:0] idat_count;
  logic [IDAT_COUNT_BITS-1:0] idat_count_next;
  logic [3:0]                 status_next;
  logic [4:0]                 kind_next;
  logic [15:0]                total_next;

  // handshake between the stages
  assign advance     = !result_valid || !result_stall;
  assign item_move   = item_valid && advance;
  assign chunk_stall = item_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!chunk_stall) begin
      item_valid <= chunk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chunk_valid && !chunk_stall) begin
      item_start                   <= start_new_file;
      item_tag                     <= chunk_tag;
      item_crc_good                <= crc_good;
      item_fields.data_length      <= data_length;
      item_fields.image_width      <= image_width;
      item_fields.image_height     <= image_height;
      item_fields.depth_byte       <= depth_byte;
      item_fields.colour_byte      <= colour_byte;
      item_fields.compression_byte <= compression_byte;
      item_fields.filter_byte      <= filter_byte;
      item_fields.interlace_byte   <= interlace_byte;
    end
  end

  pnc_judge #(
    .IDAT_COUNT_BITS (IDAT_COUNT_BITS)
  ) u_judge (
    .start_new_file  (item_start),
    .chunk_tag       (item_tag),
    .crc_good        (item_crc_good),
    .fields          (item_fields),
    .state           (state),
    .idat_count      (idat_count),
    .status          (status_next),
    .chunk_kind      (kind_next),
    .state_next      (state_next),
    .idat_count_next (idat_count_next)
  );

  // reported count saturates at the output width, or at the counter width if narrower
  generate
    if (IDAT_COUNT_BITS > 16) begin : g_total_sat
      assign total_next = (|idat_count_next[IDAT_COUNT_BITS-1:16]) ? 16'hFFFF :
                          idat_count_next[15:0];
    end else begin : g_total_ext
      assign total_next = 16'(idat_count_next);
    end
  endgenerate

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      idat_count <= '0;
    end else if (item_move) begin
      state      <= state_next;
      idat_count <= idat_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      status     <= status_next;
      chunk_kind <= kind_next;
      idat_total <= total_next;
    end
  end

endmodule

FILE: src/pnc_checker.sv
// pnc_checker: port level assertions for the png chunk order checker, bound to the top
// depends on pnc_pkg and png_chunk_order_checker
`timescale 1ns / 1ps
module pnc_checker
  import pnc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        chunk_valid,
  input logic        chunk_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [3:0]  status,
  input logic [4:0]  chunk_kind,
  input logic [15:0] idat_total
);

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // the input side only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (chunk_valid && chunk_stall) |-> (result_valid && result_stall))
    else $error("input stalled while result side free");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(status) && $stable(chunk_kind) && $stable(idat_total)))
    else $error("stalled result changed");

  // not-first only for header chunks
  a_not_first: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == ST_IHDR_NOT_FIRST)) |-> (chunk_kind == KIND_IHDR))
    else $error("not-first status on a non-header chunk");

  // a gap needs an earlier data chunk
  a_idat_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == ST_IDAT_GAP)) |->
      ((chunk_kind == KIND_IDAT) && (idat_total != 16'd0)))
    else $error("data gap without earlier data chunk");

endmodule

bind png_chunk_order_checker pnc_checker u_pnc_checker (.*);
